// ===== sv/keyframe_median_decode_mode_unit_macros.svh =====
// Assertion helpers shared by the keyframe median decode mode unit.
// All of them sample on clk and stay quiet while arst_n is low.
`ifndef KEYFRAME_MEDIAN_DECODE_MODE_UNIT_MACROS_SVH
`define KEYFRAME_MEDIAN_DECODE_MODE_UNIT_MACROS_SVH

// Plain invariant.
`define KFMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define KFMD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KFMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/kfmd_pkg.sv =====
`default_nettype none

package kfmd_pkg;

	localparam int GAPS      = 8;
	localparam int GAP_W     = 32;
	localparam int PER_W     = 10;
	localparam int CNT_W     = $clog2(GAPS + 1);
	localparam int STEP_W    = (GAPS > 1) ? $clog2(GAPS) : 1;

	localparam logic [PER_W-1:0]  PER_RESET = PER_W'(1000);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GAPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MODE
	} state_t;

	// One window entry as it moves along the chain.
	typedef struct packed {
		logic             vld;
		logic [GAP_W-1:0] gap;
	} cell_t;

	// Chain control: adv moves every entry one cell on; load feeds a new gap
	// into the head (the tail entry drops), otherwise the tail wraps around.
	typedef struct packed {
		logic             adv;
		logic             load;
		logic [GAP_W-1:0] gap;
	} win_ctl_t;

	typedef struct packed {
		logic             match;
		logic [GAP_W-1:0] cand;
	} win_res_t;

endpackage

`default_nettype wire

// ===== sv/kfmd_cell.sv =====
`default_nettype none

module kfmd_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  kfmd_pkg::cell_t             nbr,
	input  logic [kfmd_pkg::GAP_W-1:0]  cand,
	output kfmd_pkg::cell_t             cur,
	output logic                        lt,
	output logic                        le
);
	import kfmd_pkg::*;

	logic             vld_q;
	logic [GAP_W-1:0] gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= nbr.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gap_q <= nbr.gap;
		end
	end

	assign cur = '{vld: vld_q, gap: gap_q};

	// rank votes against the candidate at the head of the chain
	assign lt = vld_q && (gap_q < cand);
	assign le = vld_q && (gap_q <= cand);

endmodule

`default_nettype wire

// ===== sv/kfmd_window.sv =====
`default_nettype none

module kfmd_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kfmd_pkg::win_ctl_t          ctl,
	input  logic [kfmd_pkg::CNT_W-1:0]  rank_k,
	output kfmd_pkg::win_res_t          res
);
	import kfmd_pkg::*;

	cell_t            chain [GAPS];
	cell_t            feed  [GAPS];
	logic [GAPS-1:0]  lt;
	logic [GAPS-1:0]  le;
	logic [CNT_W-1:0] n_lt;
	logic [CNT_W-1:0] n_le;

	always_comb begin
		feed[0] = ctl.load ? '{vld: 1'b1, gap: ctl.gap} : chain[GAPS-1];
		for (int i = 1; i < GAPS; i++) begin
			feed[i] = chain[i-1];
		end
	end

	for (genvar g = 0; g < GAPS; g++) begin : g_cell
		kfmd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (ctl.adv),
			.nbr    (feed[g]),
			.cand   (chain[0].gap),
			.cur    (chain[g]),
			.lt     (lt[g]),
			.le     (le[g])
		);
	end

	assign n_lt = CNT_W'($countones(lt));
	assign n_le = CNT_W'($countones(le));

	// head entry is the median when its rank range covers rank_k
	assign res.match = chain[0].vld && (n_lt <= rank_k) && (rank_k < n_le);
	assign res.cand  = chain[0].gap;

endmodule

`default_nettype wire

// ===== sv/keyframe_median_decode_mode_unit.sv =====
// Keyframe median decode mode unit.
// Input channel (in_valid / in_stall): one packet event per item with is_video,
// is_keyframe and arrival_ms. Output channel (out_valid / out_stall): exactly
// one result item per input item with forward, full_decode, key_interval_ms.
// Config channel (cfg_valid / cfg_ready, ready always high): writes
// emit_period_ms; write it only while the unit is idle.
// A keyframe that follows an earlier keyframe pushes its gap into the cell
// chain, rotates every entry past the rank counters (ST_SEARCH), then updates
// the mode (ST_MODE, which waits for a free output register). Any other item
// loads its result into the output register when it is accepted. One item is
// in flight at a time; no new item is taken until its result is loaded.
// Reset: mode keyframe-only, no gaps, interval 0, period 1000 ms.
// A stalled receiver holds the output register; the unit then accepts no
// further item until the pending result is taken.
`default_nettype none
`include "keyframe_median_decode_mode_unit_macros.svh"

module keyframe_median_decode_mode_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [kfmd_pkg::PER_W-1:0]  emit_period_ms,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        is_video,
	input  logic                        is_keyframe,
	input  logic [kfmd_pkg::GAP_W-1:0]  arrival_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        forward,
	output logic                        full_decode,
	output logic [kfmd_pkg::GAP_W-1:0]  key_interval_ms
);
	import kfmd_pkg::*;

	state_t            state_q, state_d;
	logic [PER_W-1:0]  period_q;
	logic [GAP_W-1:0]  last_key_q;
	logic              have_key_q;
	logic [CNT_W-1:0]  count_q;
	logic [GAP_W-1:0]  median_q;
	logic              full_q;
	logic [STEP_W-1:0] step_q;

	logic              out_vld_q;
	logic              fwd_q;
	logic              full_out_q;
	logic [GAP_W-1:0]  ivl_q;

	win_ctl_t          win_ctl;
	win_res_t          win_res;
	logic              in_acc;
	logic              out_free;
	logic              key_take;
	logic              gap_push;
	logic              med_take;
	logic              mode_take;
	logic              out_load;
	logic              out_fwd_d;
	logic              enter_hit;
	logic              leave_hit;
	logic              new_full;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_vld_q || !out_stall;
	assign key_take  = in_acc && is_video && is_keyframe;

	// Hysteresis without division: m > floor(3p/2) iff 2m > 3p, and
	// m > floor(11p/10) iff 10m > 11p.
	assign enter_hit = {1'b0, median_q, 1'b0} >
		(GAP_W + 2)'({2'b00, period_q} + {1'b0, period_q, 1'b0});
	assign leave_hit = (GAP_W + 4)'({1'b0, median_q, 3'b000} + {3'b000, median_q, 1'b0}) >
		(GAP_W + 4)'((PER_W + 4)'(period_q) * (PER_W + 4)'(11));
	assign new_full  = (median_q == '0) ? full_q : (full_q ? leave_hit : enter_hit);

	kfmd_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.rank_k (count_q >> 1),
		.res    (win_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		win_ctl   = '0;
		gap_push  = 1'b0;
		med_take  = 1'b0;
		mode_take = 1'b0;
		out_load  = 1'b0;
		out_fwd_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = out_vld_q && out_stall;
				if (in_valid && !in_stall) begin
					if (is_video && is_keyframe && have_key_q) begin
						// push the new gap, then rank the window
						gap_push     = 1'b1;
						win_ctl.adv  = 1'b1;
						win_ctl.load = 1'b1;
						win_ctl.gap  = arrival_ms - last_key_q;
						state_d      = ST_SEARCH;
					end else begin
						out_load  = 1'b1;
						mode_take = is_video && is_keyframe;
						out_fwd_d = is_video && (is_keyframe || full_q);
					end
				end
			end
			ST_SEARCH: begin
				// rotate the ring; each entry visits the head once
				win_ctl.adv = 1'b1;
				med_take    = win_res.match;
				if (step_q == STEP_LAST) begin
					state_d = ST_MODE;
				end
			end
			ST_MODE: begin
				if (out_free) begin
					out_load  = 1'b1;
					mode_take = 1'b1;
					out_fwd_d = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PER_RESET;
			last_key_q <= '0;
			have_key_q <= 1'b0;
			count_q    <= '0;
			median_q   <= '0;
			full_q     <= 1'b0;
			step_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				period_q <= emit_period_ms;
			end
			if (key_take) begin
				last_key_q <= arrival_ms;
				have_key_q <= 1'b1;
			end
			if (gap_push && (count_q != CNT_W'(GAPS))) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (med_take) begin
				median_q <= win_res.cand;
			end
			if (mode_take) begin
				full_q <= new_full;
			end
			step_q <= (state_q == ST_SEARCH) ? step_q + STEP_W'(1) : '0;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// hold the result payload until it is taken
	always_ff @(posedge clk) begin
		if (out_load) begin
			fwd_q      <= out_fwd_d;
			full_out_q <= mode_take ? new_full : full_q;
			ivl_q      <= median_q;
		end
	end

	assign out_valid       = out_vld_q;
	assign forward         = fwd_q;
	assign full_decode     = full_out_q;
	assign key_interval_ms = ivl_q;

	`KFMD_ASSERT_IMP(a_accept_idle, in_valid && !in_stall, state_q == ST_IDLE, "item accepted while busy")
	`KFMD_ASSERT(a_count_cap, count_q <= CNT_W'(GAPS), "gap count above window size")
	`KFMD_ASSERT_NEXT(a_search_end, state_q == ST_SEARCH && step_q == STEP_LAST, state_q == ST_MODE, "search did not end")
	`KFMD_ASSERT_NEXT(a_mode_emits, state_q == ST_MODE && out_free, out_valid && forward, "keyframe result missing")
	`KFMD_ASSERT_IMP(a_search_filled, state_q == ST_SEARCH, count_q != '0 && have_key_q, "ranking an empty window")

endmodule

`default_nettype wire

// ===== tb/keyframe_median_decode_mode_unit_tb.sv =====
`default_nettype none

module keyframe_median_decode_mode_unit_tb;

	localparam int GAPS        = kfmd_pkg::GAPS;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 150;
	localparam int DRAIN_WAIT  = 24;

	// One packet event as presented on the input channel.
	typedef struct packed {
		logic                       video;
		logic                       key;
		logic [kfmd_pkg::GAP_W-1:0] stamp;
	} packet_t;

	// Routing decision the unit should report for one packet.
	typedef struct packed {
		logic                       fwd;
		logic                       full;
		logic [kfmd_pkg::GAP_W-1:0] interval;
	} decision_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [kfmd_pkg::PER_W-1:0] emit_period_ms = kfmd_pkg::PER_RESET;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       is_video = 1'b0;
	logic                       is_keyframe = 1'b0;
	logic [kfmd_pkg::GAP_W-1:0] arrival_ms = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic                       forward;
	logic                       full_decode;
	logic [kfmd_pkg::GAP_W-1:0] key_interval_ms;

	keyframe_median_decode_mode_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.emit_period_ms (emit_period_ms),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.is_video       (is_video),
		.is_keyframe    (is_keyframe),
		.arrival_ms     (arrival_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.forward        (forward),
		.full_decode    (full_decode),
		.key_interval_ms(key_interval_ms)
	);

	// Packets waiting to be sent, and decisions waiting for their result item.
	packet_t   pending_packets[$];
	decision_t pending_decisions[$];

	// Shadow of the unit's state, advanced at each accepted packet.
	logic [kfmd_pkg::PER_W-1:0] period_ms = kfmd_pkg::PER_RESET;
	logic [kfmd_pkg::GAP_W-1:0] prev_key_ms = '0;
	logic                       seen_key = 1'b0;
	logic [kfmd_pkg::GAP_W-1:0] gap_hist[GAPS];
	int                         gap_fill = 0;
	int                         gap_slot = 0;
	logic [kfmd_pkg::GAP_W-1:0] median_ms = '0;
	logic                       full_dec = 1'b0;

	// Stimulus generator state: running keyframe clock and the threshold
	// it currently aims the gaps at.
	logic [kfmd_pkg::GAP_W-1:0] key_clock = '0;
	bit                         aim_enter = 1'b1;

	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] enter_limit(input logic [kfmd_pkg::PER_W-1:0] p);
		return 32'(p) * 32'd3 / 32'd2;
	endfunction

	function automatic logic [31:0] leave_limit(input logic [kfmd_pkg::PER_W-1:0] p);
		return 32'(p) * 32'd11 / 32'd10;
	endfunction

	// Draw a wait for one item; no wait at all while the side is calm.
	function automatic int unsigned pick_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	// Advance the shadow state by one packet and return the decision.
	function automatic decision_t route_packet(input packet_t pkt);
		decision_t                  d;
		logic [kfmd_pkg::GAP_W-1:0] sorted_gaps[GAPS];
		logic [kfmd_pkg::GAP_W-1:0] v;
		int                         i;
		int                         j;
		if (pkt.video && pkt.key) begin
			if (seen_key) begin
				gap_hist[gap_slot] = pkt.stamp - prev_key_ms;
				gap_slot = (gap_slot + 1) % GAPS;
				if (gap_fill < GAPS)
					gap_fill++;
				// Sort the filled part of the window and take rank fill/2.
				for (i = 0; i < gap_fill; i++)
					sorted_gaps[i] = gap_hist[i];
				for (i = 1; i < gap_fill; i++) begin
					v = sorted_gaps[i];
					j = i - 1;
					while (j >= 0 && sorted_gaps[j] > v) begin
						sorted_gaps[j + 1] = sorted_gaps[j];
						j--;
					end
					sorted_gaps[j + 1] = v;
				end
				median_ms = sorted_gaps[gap_fill / 2];
			end
			prev_key_ms = pkt.stamp;
			seen_key = 1'b1;
			// Hysteresis: a zero interval holds the mode.
			if (median_ms != '0) begin
				if (full_dec)
					full_dec = median_ms > leave_limit(period_ms);
				else
					full_dec = median_ms > enter_limit(period_ms);
			end
		end
		d.fwd = pkt.video && (pkt.key || full_dec);
		d.full = full_dec;
		d.interval = median_ms;
		return d;
	endfunction

	task automatic queue_packet(input logic video, input logic key, input logic [31:0] stamp);
		packet_t pkt;
		pkt.video = video;
		pkt.key = key;
		pkt.stamp = stamp;
		pending_packets.insert(pending_packets.size(), pkt);
	endtask

	// Queue a keyframe whose gap straddles a threshold, hits zero, or is noise.
	task automatic queue_keyframe();
		logic [31:0] gap;
		case ($urandom_range(0, 9))
			0: gap = '0;
			1: gap = $urandom_range(0, 2 * int'(period_ms) + 3);
			2: gap = $urandom;
			default: gap = (aim_enter ? enter_limit(period_ms) : leave_limit(period_ms))
				+ 32'($urandom_range(0, 2)) - 32'd1;
		endcase
		if ($urandom_range(0, 11) == 0)
			aim_enter = !aim_enter;
		key_clock = key_clock + gap;
		queue_packet(1'b1, 1'b1, key_clock);
	endtask

	// Mostly keyframe runs with video in between; some noise events.
	task automatic queue_random_packets(input int count);
		int video_items;
		int r;
		video_items = 0;
		while (video_items < count) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				queue_keyframe();
				video_items++;
			end else if (r < 78) begin
				queue_packet(1'b1, 1'b0, $urandom);
				video_items++;
			end else if (r < 90) begin
				queue_packet(1'b0, 1'($urandom_range(0, 1)), $urandom);
			end else begin
				key_clock = key_clock + $urandom;
				queue_packet(1'b1, 1'b1, key_clock);
				video_items++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_packets.size() != 0 || in_valid || pending_decisions.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_period(input logic [kfmd_pkg::PER_W-1:0] p);
		@(posedge clk);
		cfg_valid <= 1'b1;
		emit_period_ms <= p;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		period_ms = p;
		cfg_valid <= 1'b0;
	endtask

	// Driver: present the next pending packet, hold it while stalled.
	always @(posedge clk) begin : drive_packets
		packet_t pkt;
		bit      taken;
		taken = arst_n && in_valid && !in_stall;
		if (taken) begin
			pkt.video = is_video;
			pkt.key = is_keyframe;
			pkt.stamp = arrival_ms;
			pending_decisions.insert(pending_decisions.size(), route_packet(pkt));
			if ($urandom_range(0, 31) == 0)
				send_calm = !send_calm;
			send_wait = pick_wait(send_calm);
		end
		if (taken || !in_valid) begin
			if (arst_n && send_wait == 0 && pending_packets.size() != 0) begin
				pkt = pending_packets[0];
				pending_packets.delete(0);
				is_video <= pkt.video;
				is_keyframe <= pkt.key;
				arrival_ms <= pkt.stamp;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
				if (send_wait != 0)
					send_wait--;
			end
		end
	end

	// Monitor: take result items, compare with the oldest decision.
	always @(posedge clk) begin : check_results
		decision_t d;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_decisions.size() == 0) begin
				$error("result item with no packet outstanding");
				mismatch_count++;
			end else begin
				d = pending_decisions[0];
				pending_decisions.delete(0);
				if (forward !== d.fwd) begin
					$error("forward: expected %0d, got %0d", d.fwd, forward);
					mismatch_count++;
				end
				if (full_decode !== d.full) begin
					$error("full_decode: expected %0d, got %0d", d.full, full_decode);
					mismatch_count++;
				end
				if (key_interval_ms !== d.interval) begin
					$error("key_interval_ms: expected %0d, got %0d", d.interval,
						key_interval_ms);
					mismatch_count++;
				end
			end
			if ($urandom_range(0, 31) == 0)
				recv_calm = !recv_calm;
			recv_wait = pick_wait(recv_calm);
		end else if (recv_wait != 0) begin
			recv_wait--;
		end
		out_stall <= (recv_wait != 0);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : run_phases
		logic [kfmd_pkg::PER_W-1:0] phase_periods[6];
		logic [31:0]                t;
		int                         p;
		phase_periods[0] = 10'd1;
		phase_periods[1] = 10'd1023;
		phase_periods[2] = 10'd0;
		phase_periods[3] = 10'd1000;
		phase_periods[4] = 10'($urandom_range(2, 999));
		phase_periods[5] = 10'($urandom_range(1, 1000));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed run at the reset period.
		// Non-video events and a video frame before any keyframe.
		queue_packet(1'b0, 1'b1, 32'hFFFF_FFFF);
		queue_packet(1'b0, 1'b0, 32'h0000_0000);
		queue_packet(1'b1, 1'b0, 32'h0000_0005);
		// First keyframe only records its time; the next one wraps past zero.
		queue_packet(1'b1, 1'b1, 32'hFFFF_FF00);
		queue_packet(1'b1, 1'b1, 32'h0000_0100);
		// Zero gaps until the median itself drops to zero.
		queue_packet(1'b1, 1'b1, 32'h0000_0100);
		queue_packet(1'b1, 1'b1, 32'h0000_0100);
		// Long gaps push the median over the entry threshold.
		t = 32'h0000_0100;
		repeat (3) begin
			t = t + 32'd2000;
			queue_packet(1'b1, 1'b1, t);
		end
		queue_packet(1'b1, 1'b0, t + 32'd7);
		// Fill the window and wrap over its oldest slot.
		repeat (3) begin
			t = t + 32'd2000;
			queue_packet(1'b1, 1'b1, t);
		end
		// Gaps exactly at the exit threshold drop back to keyframe-only.
		repeat (5) begin
			t = t + 32'd1100;
			queue_packet(1'b1, 1'b1, t);
		end
		queue_packet(1'b1, 1'b0, t + 32'd1);
		// Largest possible gap, an ignored keyframe flag, then a zero gap.
		t = t + 32'hFFFF_FFFF;
		queue_packet(1'b1, 1'b1, t);
		queue_packet(1'b0, 1'b1, 32'h0000_0000);
		queue_packet(1'b1, 1'b1, t);
		key_clock = t;
		wait_drained();

		// Random phases, each under its own period, extremes first.
		for (p = 0; p < 6; p++) begin
			repeat (2) @(posedge clk);
			write_period(phase_periods[p]);
			queue_random_packets(PHASE_ITEMS);
			wait_drained();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
